/* hdl/bsgw_pkg.sv */
package bsgw_pkg;

    // Default sizing of the vertex store and the heuristic words.
    localparam int MAX_VERTICES_DEF   = 16;
    localparam int HEURISTIC_BITS_DEF = 8;

    // Widths that cover the whole supported range of MAX_VERTICES (up to 64).
    localparam int LIM_IDX_W = 6;
    localparam int LIM_CNT_W = 7;

    // Field widths of the stream payloads and the configuration port.
    localparam int VERTEX_W = 4;
    localparam int OP_W     = 2;
    localparam int WEIGHT_W = 8;
    localparam int HVAL_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_HEUR = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN       = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] STAT_EXPANDING = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_VERTEX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_EXPAND
    } t_state;

    // Command broadcast from the sequencer to every vertex cell.
    typedef struct packed {
        logic                  clear;
        logic                  seed;
        logic [LIM_IDX_W-1:0]  seed_idx;
        logic                  take;
        logic [LIM_IDX_W-1:0]  take_idx;
        logic                  expand;
        logic [LIM_IDX_W-1:0]  expand_idx;
        logic [LIM_CNT_W-1:0]  used;
        logic                  load_edge;
        logic                  load_heur;
        logic [VERTEX_W-1:0]   load_row;
        logic [VERTEX_W-1:0]   load_col;
        logic                  edge_set;
        logic [HVAL_W-1:0]     heur_val;
    } t_cell_cmd;

endpackage

/* hdl/beam_search_graph_walk.sv */
// Channel   Direction  Transfer carries
// s_axis    in         one load item (edge or heuristic) or one run request
// m_axis    out        one expanded vertex, or the not-found result; tlast ends a run
// cfg       in         one register write, no handshake
//
// A run picks each vertex from the queue by a token that ripples through the row of
// vertex cells, expands the picked vertices one at a time, and makes one more token
// pass in each round that ends short of the beam width, the final check of an empty
// queue included. A stalled output holds expansion; items are taken only while
// no run is active. Reset clears flags and sets the configuration to its defaults;
// the adjacency and heuristic stores hold no defined value until written.
module beam_search_graph_walk import bsgw_pkg::*; #(
    parameter int MAX_VERTICES   = MAX_VERTICES_DEF,
    parameter int HEURISTIC_BITS = HEURISTIC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // vertex_index[3:0], neighbor_index[7:4], edge_weight[15:8], heuristic_value[23:16]
    input  logic [23:0]          i_s_axis_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]      i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // expanded_vertex[3:0], zero[7:4]
    output logic [7:0]           o_m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);

    localparam int IDX_W = $clog2(MAX_VERTICES);

    t_cell_cmd                 cmd;
    logic                      tok_valid [MAX_VERTICES];
    logic [HEURISTIC_BITS-1:0] tok_h     [MAX_VERTICES];
    logic [IDX_W-1:0]          tok_idx   [MAX_VERTICES];
    logic [VERTEX_W-1:0]       m_vertex;

    // Sequencer.
    bsgw_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_s_op       (i_s_axis_tuser),
        .i_s_vertex   (i_s_axis_tdata[3:0]),
        .i_s_neighbor (i_s_axis_tdata[7:4]),
        .i_s_weight   (i_s_axis_tdata[15:8]),
        .i_s_heur     (i_s_axis_tdata[23:16]),
        .i_tok_valid  (tok_valid[MAX_VERTICES-1]),
        .i_tok_idx    (tok_idx[MAX_VERTICES-1]),
        .o_cmd        (cmd),
        .o_m_valid    (o_m_axis_tvalid),
        .i_m_ready    (i_m_axis_tready),
        .o_m_vertex   (m_vertex),
        .o_m_status   (o_m_axis_tuser),
        .o_m_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0, m_vertex};

    // Row of vertex cells; the best-candidate token moves one cell per cycle.
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        if (g == 0) begin : g_head
            bsgw_cell #(
                .MAX_VERTICES   (MAX_VERTICES),
                .HEURISTIC_BITS (HEURISTIC_BITS),
                .CELL_ID        (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_tok_valid (1'b0),
                .i_tok_h     ('0),
                .i_tok_idx   ('0),
                .o_tok_valid (tok_valid[g]),
                .o_tok_h     (tok_h[g]),
                .o_tok_idx   (tok_idx[g])
            );
        end else begin : g_body
            bsgw_cell #(
                .MAX_VERTICES   (MAX_VERTICES),
                .HEURISTIC_BITS (HEURISTIC_BITS),
                .CELL_ID        (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_tok_valid (tok_valid[g-1]),
                .i_tok_h     (tok_h[g-1]),
                .i_tok_idx   (tok_idx[g-1]),
                .o_tok_valid (tok_valid[g]),
                .o_tok_h     (tok_h[g]),
                .o_tok_idx   (tok_idx[g])
            );
        end
    end

endmodule

/* hdl/bsgw_cell.sv */
module bsgw_cell import bsgw_pkg::*; #(
    parameter int MAX_VERTICES   = MAX_VERTICES_DEF,
    parameter int HEURISTIC_BITS = HEURISTIC_BITS_DEF,
    parameter int CELL_ID        = 0,
    localparam int IDX_W         = $clog2(MAX_VERTICES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_cmd                 i_cmd,
    input  logic                      i_tok_valid,
    input  logic [HEURISTIC_BITS-1:0] i_tok_h,
    input  logic [IDX_W-1:0]          i_tok_idx,
    output logic                      o_tok_valid,
    output logic [HEURISTIC_BITS-1:0] o_tok_h,
    output logic [IDX_W-1:0]          o_tok_idx
);

    // Heuristic of this vertex and its incoming edges (one bit per source row).
    logic [HEURISTIC_BITS-1:0] r_heur;
    logic [MAX_VERTICES-1:0]   r_col;
    logic                      r_queued;
    logic                      r_visited;
    logic                      r_tok_valid;
    logic [HEURISTIC_BITS-1:0] r_tok_h;
    logic [IDX_W-1:0]          r_tok_idx;

    logic        n_queued;
    logic        n_visited;
    logic        in_use;
    logic        is_mine_seed;
    logic        is_mine_take;
    logic        fresh;
    logic        own_wins;
    logic [31:0] row32;
    logic [31:0] exp32;
    logic [31:0] hv32;

    assign in_use       = 32'(CELL_ID) < 32'(i_cmd.used);
    assign is_mine_seed = 32'(i_cmd.seed_idx) == 32'(CELL_ID);
    assign is_mine_take = 32'(i_cmd.take_idx) == 32'(CELL_ID);
    assign row32        = 32'(i_cmd.load_row);
    assign exp32        = 32'(i_cmd.expand_idx);
    assign hv32         = 32'(i_cmd.heur_val);

    // An expanded vertex reaches this one when it has an edge here.
    assign fresh = i_cmd.expand && in_use && !r_visited && r_col[exp32[IDX_W-1:0]];

    // Queue and visited flags of this vertex.
    always_comb begin
        n_queued  = r_queued;
        n_visited = r_visited;
        if (i_cmd.clear) begin
            n_queued  = i_cmd.seed && is_mine_seed;
            n_visited = i_cmd.seed && is_mine_seed;
        end else if (i_cmd.take && is_mine_take) begin
            n_queued = 1'b0;
        end else if (fresh) begin
            n_queued  = 1'b1;
            n_visited = 1'b1;
        end
    end

    // Strictly lower heuristic wins; on a tie the lower index upstream keeps the token.
    assign own_wins = r_queued && (!i_tok_valid || (r_heur < i_tok_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued    <= 1'b0;
            r_visited   <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_queued    <= n_queued;
            r_visited   <= n_visited;
            r_tok_valid <= i_tok_valid || r_queued;
        end
    end

    // Store writes and the best-candidate token handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_heur && (32'(i_cmd.load_row) == 32'(CELL_ID))) begin
            r_heur <= hv32[HEURISTIC_BITS-1:0];
        end
        if (i_cmd.load_edge && (32'(i_cmd.load_col) == 32'(CELL_ID))) begin
            r_col[row32[IDX_W-1:0]] <= i_cmd.edge_set;
        end
        if (own_wins) begin
            r_tok_h   <= r_heur;
            r_tok_idx <= IDX_W'(CELL_ID);
        end else begin
            r_tok_h   <= i_tok_h;
            r_tok_idx <= i_tok_idx;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok_h     = r_tok_h;
    assign o_tok_idx   = r_tok_idx;

endmodule

/* hdl/bsgw_ctrl.sv */
module bsgw_ctrl import bsgw_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int IDX_W       = $clog2(MAX_VERTICES),
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [OP_W-1:0]       i_s_op,
    input  logic [VERTEX_W-1:0]   i_s_vertex,
    input  logic [VERTEX_W-1:0]   i_s_neighbor,
    input  logic [WEIGHT_W-1:0]   i_s_weight,
    input  logic [HVAL_W-1:0]     i_s_heur,
    input  logic                  i_tok_valid,
    input  logic [IDX_W-1:0]      i_tok_idx,
    output t_cell_cmd             o_cmd,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [VERTEX_W-1:0]   o_m_vertex,
    output logic [STATUS_W-1:0]   o_m_status,
    output logic                  o_m_last
);

    localparam int WAIT_W = $clog2(MAX_VERTICES + 1);

    // Configuration registers.
    logic [VERTEX_W-1:0] r_start;
    logic [VERTEX_W-1:0] r_goal;
    logic [CFG_W-1:0]    r_beam;
    logic [CFG_W-1:0]    r_vcount;

    t_state               r_state;
    t_state               n_state;
    logic [WAIT_W-1:0]    r_wait;
    logic [WAIT_W-1:0]    n_wait;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [CNT_W-1:0]     r_j;
    logic [CNT_W-1:0]     n_j;
    logic [IDX_W-1:0]     r_taken [MAX_VERTICES];
    logic                 taken_we;

    logic                 r_out_valid;
    logic [VERTEX_W-1:0]  r_out_vertex;
    logic [STATUS_W-1:0]  r_out_status;
    logic                 r_out_last;
    logic                 out_load;
    logic [VERTEX_W-1:0]  n_out_vertex;
    logic [STATUS_W-1:0]  n_out_status;
    logic                 n_out_last;

    logic                 accept;
    logic                 out_free;
    logic                 tok_done;
    logic                 round_full;
    logic                 last_j;
    logic                 is_goal;
    logic [IDX_W-1:0]     cur_v;
    logic [31:0]          cur_v32;
    logic [CFG_W-1:0]     bw_eff;
    logic [LIM_CNT_W-1:0] used;
    t_cell_cmd            cmd;

    // Effective beam width and vertex count after clamping.
    assign bw_eff = (r_beam == '0) ? CFG_W'(1) : r_beam;
    always_comb begin
        if (r_vcount == '0) begin
            used = LIM_CNT_W'(1);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            used = LIM_CNT_W'(MAX_VERTICES);
        end else begin
            used = LIM_CNT_W'(r_vcount);
        end
    end

    assign o_s_ready  = (r_state == ST_IDLE);
    assign accept     = i_s_valid && o_s_ready;
    assign out_free   = !r_out_valid || i_m_ready;
    assign tok_done   = (32'(r_wait) == MAX_VERTICES);
    assign round_full = (32'(r_cnt) + 32'd1) >= 32'(bw_eff);
    assign last_j     = (32'(r_j) + 32'd1) == 32'(r_cnt);
    assign cur_v      = r_taken[r_j[IDX_W-1:0]];
    assign cur_v32    = 32'(cur_v);
    assign is_goal    = cur_v32 == 32'(r_goal);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_s_op == OP_RUN)) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (tok_done) begin
                    if (i_tok_valid) begin
                        n_state = round_full ? ST_EXPAND : ST_SELECT;
                    end else if (r_cnt == '0) begin
                        n_state = out_free ? ST_IDLE : ST_SELECT;
                    end else begin
                        n_state = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND: begin
                if (out_free) begin
                    if (is_goal) begin
                        n_state = ST_IDLE;
                    end else if (last_j) begin
                        n_state = ST_SELECT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the cells, counters and the result register.
    always_comb begin
        cmd          = '0;
        cmd.used     = used;
        n_wait       = (32'(r_wait) < MAX_VERTICES) ? (r_wait + 1'b1) : r_wait;
        n_cnt        = r_cnt;
        n_j          = r_j;
        taken_we     = 1'b0;
        out_load     = 1'b0;
        n_out_vertex = r_out_vertex;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_s_op)
                        OP_LOAD_EDGE: begin
                            cmd.load_edge = (32'(i_s_vertex) < MAX_VERTICES)
                                && (32'(i_s_neighbor) < MAX_VERTICES);
                            cmd.load_row  = i_s_vertex;
                            cmd.load_col  = i_s_neighbor;
                            cmd.edge_set  = (i_s_weight != '0);
                        end
                        OP_LOAD_HEUR: begin
                            cmd.load_heur = (32'(i_s_vertex) < MAX_VERTICES);
                            cmd.load_row  = i_s_vertex;
                            cmd.heur_val  = i_s_heur;
                        end
                        OP_RUN: begin
                            cmd.clear    = 1'b1;
                            cmd.seed     = 32'(r_start) < 32'(used);
                            cmd.seed_idx = LIM_IDX_W'(r_start);
                            n_wait       = '0;
                            n_cnt        = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SELECT: begin
                if (tok_done) begin
                    if (i_tok_valid) begin
                        cmd.take     = 1'b1;
                        cmd.take_idx = LIM_IDX_W'(i_tok_idx);
                        taken_we     = 1'b1;
                        n_cnt        = r_cnt + 1'b1;
                        n_wait       = '0;
                        n_j          = '0;
                    end else if (r_cnt == '0) begin
                        if (out_free) begin
                            out_load     = 1'b1;
                            n_out_vertex = '0;
                            n_out_status = STAT_NOT_FOUND;
                            n_out_last   = 1'b1;
                        end
                    end else begin
                        n_j = '0;
                    end
                end
            end
            ST_EXPAND: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out_vertex = cur_v32[VERTEX_W-1:0];
                    if (is_goal) begin
                        n_out_status = STAT_FOUND;
                        n_out_last   = 1'b1;
                    end else begin
                        n_out_status   = STAT_EXPANDING;
                        n_out_last     = 1'b0;
                        cmd.expand     = 1'b1;
                        cmd.expand_idx = LIM_IDX_W'(cur_v);
                        if (last_j) begin
                            n_cnt  = '0;
                            n_wait = '0;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_cmd = cmd;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= '0;
            r_cnt       <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
            r_start     <= '0;
            r_goal      <= '0;
            r_beam      <= CFG_W'(2);
            r_vcount    <= CFG_W'(16);
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_cnt   <= n_cnt;
            r_j     <= n_j;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_VERTEX: r_start  <= i_cfg_wdata[VERTEX_W-1:0];
                    CFG_GOAL_VERTEX:  r_goal   <= i_cfg_wdata[VERTEX_W-1:0];
                    CFG_BEAM_WIDTH:   r_beam   <= i_cfg_wdata;
                    CFG_VERTEX_COUNT: r_vcount <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Result payload and the list of vertices taken this round.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vertex <= n_out_vertex;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
        if (taken_we) begin
            r_taken[r_cnt[IDX_W-1:0]] <= i_tok_idx;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_vertex = r_out_vertex;
    assign o_m_status = r_out_status;
    assign o_m_last   = r_out_last;

    // A final result always returns the sequencer to idle.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && n_out_last |=> r_state == ST_IDLE)
        else $error("final result loaded but run did not end");

    // No more picks than vertices in a round.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_VERTICES)
        else $error("pick count beyond vertex count");

    // Expansion walks only through vertices that were taken.
    a_expand_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXPAND |-> r_j < r_cnt)
        else $error("expansion index beyond taken list");

    // A pick never happens before the token chain has settled.
    a_pick_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take |-> tok_done && r_state == ST_SELECT)
        else $error("pick from an unsettled token chain");

endmodule

/* dv/beam_search_graph_walk_tb.sv */
`timescale 1ns / 1ps

module beam_search_graph_walk_tb;
    import bsgw_pkg::*;

    localparam int N_VERT        = MAX_VERTICES_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 20;

    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One expected result transfer.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [23:0]          i_s_axis_tdata;
    logic [OP_W-1:0]      i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [7:0]           o_m_axis_tdata;
    logic [STATUS_W-1:0]  o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    // Shadow copy of the graph store and the configuration.
    logic [N_VERT-1:0]   edge_rows [N_VERT];
    logic [HVAL_W-1:0]   heur_vals [N_VERT];
    logic [VERTEX_W-1:0] start_reg = '0;
    logic [VERTEX_W-1:0] goal_reg  = '0;
    logic [CFG_W-1:0]    beam_reg  = 5'd2;
    logic [CFG_W-1:0]    count_reg = 5'd16;

    t_step pending_steps[$];
    int    errors      = 0;
    int    idle_cycles = 0;
    bit    src_quiet   = 1'b0;
    bit    snk_quiet   = 1'b0;

    beam_search_graph_walk dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Append one expected result at the tail of the scoreboard.
    function automatic void add_expected(input logic [VERTEX_W-1:0] v,
                                         input logic [STATUS_W-1:0] st, input logic lst);
        t_step s;
        s.vertex = v;
        s.status = st;
        s.last   = lst;
        pending_steps = {pending_steps, s};
    endfunction

    // Beam search over the shadow graph; queues every result the run gives.
    task automatic walk_graph();
        logic [N_VERT-1:0] visited, queued, vmask, fresh;
        int n, bw, cnt, best, v;
        int picked[N_VERT];
        n = int'(count_reg);
        if (n == 0) n = 1;
        if (n > N_VERT) n = N_VERT;
        vmask = (n == N_VERT) ? '1 : ((N_VERT'(1) << n) - N_VERT'(1));
        bw = (beam_reg == 0) ? 1 : int'(beam_reg);
        visited = '0;
        queued  = '0;
        if (start_reg < n) begin
            visited[start_reg] = 1'b1;
            queued = visited;
        end
        while (queued != '0) begin
            // Take the beam: lowest heuristic first, lower index on ties.
            cnt = 0;
            while (cnt < bw) begin
                best = -1;
                for (int i = 0; i < n; i++) begin
                    if (queued[i] && (best < 0 || heur_vals[i] < heur_vals[best])) begin
                        best = i;
                    end
                end
                if (best < 0) break;
                queued[best] = 1'b0;
                picked[cnt] = best;
                cnt++;
            end
            for (int j = 0; j < cnt; j++) begin
                v = picked[j];
                if (v == int'(goal_reg)) begin
                    add_expected(VERTEX_W'(v), STAT_FOUND, 1'b1);
                    return;
                end
                add_expected(VERTEX_W'(v), STAT_EXPANDING, 1'b0);
                fresh = edge_rows[v] & vmask & ~visited;
                visited |= fresh;
                queued  |= fresh;
            end
        end
        add_expected('0, STAT_NOT_FOUND, 1'b1);
    endtask

    // Offer one item, wait for its transfer, then update the shadow state.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [3:0] vi, ni,
                             input logic [7:0] w, hv);
        int gap;
        gap = idle_len(src_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {hv, w, ni, vi};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        case (op)
            OP_LOAD_EDGE: edge_rows[vi][ni] = (w != 0);
            OP_LOAD_HEUR: heur_vals[vi] = hv;
            OP_RUN:       walk_graph();
            default: ;
        endcase
    endtask

    task automatic send_run();
        send_item(OP_RUN, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Let every expected result drain and the block fall idle.
    task automatic quiesce();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers while the block is idle.
    task automatic configure(input logic [CFG_W-1:0] s, g, b, c);
        quiesce();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_VERTEX;
        i_cfg_wdata <= s;
        @(negedge i_clk);
        i_cfg_index <= CFG_GOAL_VERTEX;
        i_cfg_wdata <= g;
        @(negedge i_clk);
        i_cfg_index <= CFG_BEAM_WIDTH;
        i_cfg_wdata <= b;
        @(negedge i_clk);
        i_cfg_index <= CFG_VERTEX_COUNT;
        i_cfg_wdata <= c;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        start_reg = s[VERTEX_W-1:0];
        goal_reg  = g[VERTEX_W-1:0];
        beam_reg  = b;
        count_reg = c;
    endtask

    // Write every adjacency entry and every heuristic so no search reads an unwritten one.
    task automatic load_whole_graph();
        logic [7:0] w;
        for (int r = 0; r < N_VERT; r++) begin
            for (int c = 0; c < N_VERT; c++) begin
                w = ($urandom_range(0, 99) < 25) ? 8'($urandom_range(1, 255)) : 8'd0;
                send_item(OP_LOAD_EDGE, 4'(r), 4'(c), w, 8'($urandom));
            end
        end
        for (int r = 0; r < N_VERT; r++) begin
            send_item(OP_LOAD_HEUR, 4'(r), 4'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Reset configuration: start equals goal, so the run ends at once; unused opcode ignored.
    task automatic test_reset_defaults();
        send_run();
        send_item(OP_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
        quiesce();
    endtask

    // Weight and heuristic extremes, edge clearing, heuristic ties and beam widths.
    task automatic test_loads_and_ties();
        send_item(OP_LOAD_EDGE, 4'd0, 4'd1, 8'hFF, 8'h00);
        send_item(OP_LOAD_EDGE, 4'd0, 4'd2, 8'h01, 8'hFF);
        send_item(OP_LOAD_EDGE, 4'd0, 4'd3, 8'h80, 8'h55);
        send_item(OP_LOAD_EDGE, 4'd0, 4'd4, 8'h7F, 8'hAA);
        send_item(OP_LOAD_EDGE, 4'd0, 4'd3, 8'h00, 8'h00);
        send_item(OP_LOAD_EDGE, 4'd15, 4'd15, 8'hFF, 8'hFF);
        send_item(OP_LOAD_HEUR, 4'd1, 4'hF, 8'hFF, 8'h00);
        send_item(OP_LOAD_HEUR, 4'd2, 4'h0, 8'h00, 8'h00);
        send_item(OP_LOAD_HEUR, 4'd3, 4'hA, 8'h5A, 8'h00);
        send_item(OP_LOAD_HEUR, 4'd4, 4'h5, 8'hA5, 8'hFF);
        send_item(OP_LOAD_HEUR, 4'd15, 4'h0, 8'h00, 8'hFF);
        configure(5'd0, 5'd4, 5'd1, 5'd5);
        send_run();
        configure(5'd0, 5'd4, 5'd0, 5'd5);
        send_run();
        configure(5'd0, 5'd4, 5'd16, 5'd5);
        send_run();
        configure(5'd16, 5'd20, 5'd31, 5'd16);
        send_run();
    endtask

    // Vertex count below and above range, start and goal outside the graph.
    task automatic test_config_corners();
        configure(5'd0, 5'd0, 5'd2, 5'd0);
        send_run();
        configure(5'd0, 5'd5, 5'd2, 5'd0);
        send_run();
        configure(5'd3, 5'd15, 5'd3, 5'd31);
        send_run();
        configure(5'd9, 5'd1, 5'd2, 5'd4);
        send_run();
        configure(5'd0, 5'd12, 5'd2, 5'd4);
        send_run();
    endtask

    // Random phases: mostly graph edits inside the active vertices followed by searches.
    task automatic test_random_phases();
        logic [CFG_W-1:0] s, g, b, c;
        int n, sent, roll;
        logic [3:0] vi;
        logic [7:0] w;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: c = 5'd0;
                1: c = 5'd1;
                2: c = 5'd16;
                3: c = 5'($urandom_range(17, 31));
                default: c = 5'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 5))
                0: b = 5'd0;
                1: b = 5'd1;
                2: b = 5'd16;
                3: b = 5'd31;
                default: b = 5'($urandom_range(1, 16));
            endcase
            n = (c == 0) ? 1 : ((c > N_VERT) ? N_VERT : int'(c));
            s = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, n - 1)) : 5'($urandom);
            g = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, n - 1)) : 5'($urandom);
            s[4] = 1'($urandom_range(0, 1));
            g[4] = 1'($urandom_range(0, 1));
            configure(s, g, b, c);
            src_quiet = (p % 4 == 1) || (p % 4 == 3);
            snk_quiet = (p % 4 == 2) || (p % 4 == 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                vi = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, n - 1))
                                                 : 4'($urandom);
                if (roll < 45) begin
                    w = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                    send_item(OP_LOAD_EDGE, vi, ($urandom_range(0, 4) != 0) ?
                              4'($urandom_range(0, n - 1)) : 4'($urandom), w,
                              8'($urandom));
                    sent++;
                end else if (roll < 70) begin
                    send_item(OP_LOAD_HEUR, vi, 4'($urandom), 8'($urandom), 8'($urandom));
                    sent++;
                end else if (roll < 95) begin
                    send_run();
                    sent++;
                end else begin
                    send_item(OP_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom),
                              8'($urandom));
                end
            end
        end
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
    endtask

    // Output side: random stalls on tready.
    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                stall_left = idle_len(snk_quiet);
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_step want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0h status %0d last %0b",
                         $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                errors++;
            end else begin
                want = pending_steps.pop_front();
                if (o_m_axis_tdata !== {4'b0, want.vertex}) begin
                    $display("%0t: expanded vertex mismatch: expected %0h, actual %0h",
                             $time, {4'b0, want.vertex}, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last flag mismatch: expected %0b, actual %0b",
                             $time, want.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_START_VERTEX;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_LOAD_EDGE;
        for (int r = 0; r < N_VERT; r++) begin
            edge_rows[r] = '0;
            heur_vals[r] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_whole_graph();
        test_reset_defaults();
        test_loads_and_ties();
        test_config_corners();
        test_random_phases();
        quiesce();

        if (errors == 0 && pending_steps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* beam_search_graph_walk.f */
hdl/bsgw_pkg.sv
hdl/bsgw_cell.sv
hdl/bsgw_ctrl.sv
hdl/beam_search_graph_walk.sv
dv/beam_search_graph_walk_tb.sv
